// ----- sv/uafr_pkg.sv -----
`default_nettype none

package uafr_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 256;

    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_AMP    = 8'h26;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd200;
    localparam logic       FRAME_MODE_RESET = 1'b1;

    localparam logic REG_FRAME_MODE = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    localparam logic MODE_LINE   = 1'b0;
    localparam logic MODE_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_RECEIVE  = 2'd1;
    localparam logic [1:0] ST_CR_SEEN  = 2'd2;
    localparam logic [1:0] ST_COMPLETE = 2'd3;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_DOLLAR  = 2'd1;
    localparam logic [1:0] KIND_COMMAND = 2'd2;

endpackage

`default_nettype wire

// ----- sv/uart_frame_receiver.sv -----
// Frame receiver for bytes coming from a serial receiver.
// Input words arrive on the s_axis channel: tuser carries the operation
// (received byte, read a buffer entry, release a completed frame, none) and tdata
// carries the received byte and the read index. Every input word gives exactly
// one result word on the m_axis channel: status, received count, declared
// length, read byte and dropped flag in tdata, and the frame kind in tuser.
// A word is accepted every cycle while results keep draining; frame state and
// the buffer are updated at the accepting edge, so the next word sees them.
// The buffer read is registered, and each result passes through the s1
// register and then the output register before it appears on m_axis.
// Two result registers sit between the channels, so a word is still taken
// while an earlier result waits on m_axis; once both are full, s_axis_tready
// drops until m_axis_tready takes a result.
// The APB port sets frame_mode (address 0) and max_length (address 4); a
// write to frame_mode discards any frame in progress. Registers must be
// written only while the block is idle; the block does not enforce this.
// Reset clears the frame state and both result registers and loads the
// register defaults; the buffer contents are left undefined.
`default_nettype none

module uart_frame_receiver #(
    parameter int BUFFER_DEPTH = uafr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] rx_byte, [15:8] read_index
    input  wire logic [15:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [9:2] received_count, [17:10] declared_length,
    // [25:18] read_byte, [26] dropped, [31:27] zero
    output logic [31:0]      m_axis_tdata,
    // [1:0] frame_kind
    output logic [1:0]       m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_mem_q;

    logic       r_mode;
    logic [7:0] r_max;

    logic [7:0] r_count;
    logic       r_open;
    logic       r_cr;
    logic       r_done;
    logic [7:0] r_len;
    logic [1:0] r_kind;

    logic [7:0] n_count;
    logic       n_open;
    logic       n_cr;
    logic       n_done;
    logic [7:0] n_len;
    logic [1:0] n_kind;
    logic       n_drop;
    logic       n_wr_en;
    logic [7:0] n_wr_pos;
    logic [1:0] n_status;

    logic       r_s1_valid;
    logic [1:0] r_s1_status;
    logic [1:0] r_s1_kind;
    logic [7:0] r_s1_count;
    logic [7:0] r_s1_len;
    logic       r_s1_drop;
    logic       r_s1_rd_en;

    logic        r_out_valid;
    logic [31:0] r_out_tdata;
    logic [1:0]  r_out_tuser;

    uafr_pkg::t_op op;
    logic [7:0]    rx_byte;
    logic [7:0]    read_index;
    logic [7:0]    cnt_inc;
    logic          accept;
    logic          s1_move;
    logic          cfg_wr;
    logic          rd_in_range;
    logic [7:0]    s1_read_byte;

    assign op         = uafr_pkg::t_op'(s_axis_tuser);
    assign rx_byte    = s_axis_tdata[7:0];
    assign read_index = s_axis_tdata[15:8];
    assign cnt_inc    = r_count + 8'd1;

    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == uafr_pkg::REG_FRAME_MODE) ? {31'd0, r_mode}
                                                            : {24'd0, r_max};

    assign rd_in_range = (32'(read_index) < BUFFER_DEPTH);

    always_comb begin
        n_count  = r_count;
        n_open   = r_open;
        n_cr     = r_cr;
        n_done   = r_done;
        n_len    = r_len;
        n_kind   = r_kind;
        n_drop   = 1'b0;
        n_wr_en  = 1'b0;
        n_wr_pos = r_count;
        unique case (op)
            uafr_pkg::OP_BYTE: begin
                if (r_mode == uafr_pkg::MODE_LINE) begin
                    if (!r_done) begin
                        if (r_cr) begin
                            if (rx_byte != uafr_pkg::CHAR_LF) begin
                                n_count = 8'd0;
                                n_open  = 1'b0;
                                n_cr    = 1'b0;
                                n_len   = 8'd0;
                                n_kind  = uafr_pkg::KIND_NONE;
                                n_drop  = 1'b1;
                            end else begin
                                n_wr_en = 1'b1;
                                n_done  = 1'b1;
                            end
                        end else begin
                            n_wr_en = 1'b1;
                            n_open  = 1'b1;
                            n_count = cnt_inc;
                            if (rx_byte == uafr_pkg::CHAR_CR) begin
                                n_cr = 1'b1;
                            end else if (cnt_inc >= r_max) begin
                                n_count = 8'd0;
                                n_open  = 1'b0;
                                n_len   = 8'd0;
                                n_kind  = uafr_pkg::KIND_NONE;
                                n_drop  = 1'b1;
                            end
                        end
                    end
                end else begin
                    if (!r_open) begin
                        if (rx_byte == uafr_pkg::CHAR_DOLLAR ||
                            rx_byte == uafr_pkg::CHAR_AMP) begin
                            n_wr_en  = 1'b1;
                            n_wr_pos = 8'd0;
                            n_open   = 1'b1;
                            n_count  = 8'd1;
                            n_cr     = 1'b0;
                            n_done   = 1'b0;
                            n_len    = 8'd0;
                            n_kind   = (rx_byte == uafr_pkg::CHAR_DOLLAR) ?
                                       uafr_pkg::KIND_DOLLAR : uafr_pkg::KIND_COMMAND;
                        end
                    end else if (!r_done) begin
                        if (r_count >= r_max) begin
                            n_count = 8'd0;
                            n_open  = 1'b0;
                            n_cr    = 1'b0;
                            n_len   = 8'd0;
                            n_kind  = uafr_pkg::KIND_NONE;
                            n_drop  = 1'b1;
                        end else begin
                            n_wr_en = 1'b1;
                            if (r_count == 8'd1) begin
                                n_len = rx_byte;
                            end
                            n_count = cnt_inc;
                            if ({1'b0, cnt_inc} == ({1'b0, n_len} + 9'd2)) begin
                                n_done = 1'b1;
                            end
                        end
                    end
                end
            end
            uafr_pkg::OP_RELEASE: begin
                if (r_done) begin
                    n_count = 8'd0;
                    n_open  = 1'b0;
                    n_cr    = 1'b0;
                    n_done  = 1'b0;
                    n_len   = 8'd0;
                    n_kind  = uafr_pkg::KIND_NONE;
                end
            end
            uafr_pkg::OP_READ, uafr_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase

        priority if (n_done) begin
            n_status = uafr_pkg::ST_COMPLETE;
        end else if (n_cr) begin
            n_status = uafr_pkg::ST_CR_SEEN;
        end else if (n_open) begin
            n_status = uafr_pkg::ST_RECEIVE;
        end else begin
            n_status = uafr_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_wr_en && (32'(n_wr_pos) < BUFFER_DEPTH)) begin
            r_mem[AW'(n_wr_pos)] <= rx_byte;
        end
        if (accept) begin
            r_mem_q <= r_mem[AW'(read_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= uafr_pkg::FRAME_MODE_RESET;
            r_max   <= uafr_pkg::MAX_LENGTH_RESET;
            r_count <= 8'd0;
            r_open  <= 1'b0;
            r_cr    <= 1'b0;
            r_done  <= 1'b0;
            r_len   <= 8'd0;
            r_kind  <= uafr_pkg::KIND_NONE;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_open  <= n_open;
                r_cr    <= n_cr;
                r_done  <= n_done;
                r_len   <= n_len;
                r_kind  <= n_kind;
            end
            if (cfg_wr && paddr[2] == uafr_pkg::REG_FRAME_MODE) begin
                r_mode  <= pwdata[0];
                r_count <= 8'd0;
                r_open  <= 1'b0;
                r_cr    <= 1'b0;
                r_done  <= 1'b0;
                r_len   <= 8'd0;
                r_kind  <= uafr_pkg::KIND_NONE;
            end
            if (cfg_wr && paddr[2] == uafr_pkg::REG_MAX_LENGTH) begin
                r_max <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_status <= n_status;
            r_s1_kind   <= n_kind;
            r_s1_count  <= n_count;
            r_s1_len    <= n_len;
            r_s1_drop   <= n_drop;
            r_s1_rd_en  <= (op == uafr_pkg::OP_READ) && rd_in_range;
        end
    end

    assign s1_read_byte = r_s1_rd_en ? r_mem_q : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_move) begin
            r_out_tdata <= {5'd0, r_s1_drop, s1_read_byte, r_s1_len,
                            r_s1_count, r_s1_status};
            r_out_tuser <= r_s1_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

`default_nettype wire

// ----- sv/uafr_checker.sv -----
`default_nettype none

module uafr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    ap_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[26] |->
            m_axis_tdata[1:0] == uafr_pkg::ST_IDLE && m_axis_tdata[9:2] == 8'd0 &&
            m_axis_tdata[17:10] == 8'd0 && m_axis_tuser == uafr_pkg::KIND_NONE)
        else $error("dropped frame left frame state behind");

    ap_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == uafr_pkg::ST_IDLE |->
            m_axis_tdata[9:2] == 8'd0 && m_axis_tdata[17:10] == 8'd0)
        else $error("idle status with a non-empty frame");

    ap_kind_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != uafr_pkg::KIND_NONE |->
            m_axis_tdata[1:0] != uafr_pkg::ST_IDLE)
        else $error("frame kind reported without an open frame");

endmodule

bind uart_frame_receiver uafr_checker u_uafr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/sv/tb_uart_frame_receiver.sv -----
`timescale 1ns / 100ps

module tb_uart_frame_receiver;

    localparam int GEN = 0;
    localparam int CHK = 1;

    typedef struct packed {
        uafr_pkg::t_op op;
        logic [7:0]    index;
        logic [7:0]    data;
    } t_rx_word;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic [7:0] count;
        logic [7:0] length;
        logic [7:0] entry;
        logic       dropped;
    } t_frame_report;

    typedef struct packed {
        logic       mode;
        logic [7:0] max_len;
        logic [7:0] count;
        logic       open;
        logic       cr;
        logic       done;
        logic [7:0] length;
        logic [1:0] kind;
    } t_frame_track;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;
    wire  [31:0] prdata;
    wire         pready;

    // Two copies of the frame state: one follows the words as they are made,
    // so that reads only target written entries, the other follows acceptance.
    t_frame_track  trk [2];
    logic [7:0]    frame_mem [2][256];
    bit            mem_written [2][256];

    t_rx_word      rx_words[$];
    t_frame_report frame_reports[$];
    bit            in_flight = 1'b0;
    int unsigned   words_made = 0;
    int unsigned   report_errors = 0;
    int unsigned   idle_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   hold_start = 0;
    int unsigned   hold_left = 0;

    uart_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_frame_track cleared(input t_frame_track t);
        t.count  = '0;
        t.open   = 1'b0;
        t.cr     = 1'b0;
        t.done   = 1'b0;
        t.length = '0;
        t.kind   = uafr_pkg::KIND_NONE;
        return t;
    endfunction

    function automatic void store_byte(input int side, input logic [7:0] pos,
                                       input logic [7:0] b);
        frame_mem[side][pos]   = b;
        mem_written[side][pos] = 1'b1;
    endfunction

    function automatic t_frame_report receive_word(input int side, input t_rx_word w);
        t_frame_track  t;
        t_frame_report r;
        t = trk[side];
        r = '0;
        case (w.op)
            uafr_pkg::OP_BYTE: begin
                if (t.mode == uafr_pkg::MODE_LINE) begin
                    if (!t.done) begin
                        if (t.cr) begin
                            if (w.data != uafr_pkg::CHAR_LF) begin
                                t = cleared(t);
                                r.dropped = 1'b1;
                            end else begin
                                store_byte(side, t.count, w.data);
                                t.done = 1'b1;
                            end
                        end else begin
                            store_byte(side, t.count, w.data);
                            t.open  = 1'b1;
                            t.count = t.count + 8'd1;
                            if (w.data == uafr_pkg::CHAR_CR) begin
                                t.cr = 1'b1;
                            end else if (t.count >= t.max_len) begin
                                t = cleared(t);
                                r.dropped = 1'b1;
                            end
                        end
                    end
                end else if (!t.open) begin
                    if (w.data == uafr_pkg::CHAR_DOLLAR || w.data == uafr_pkg::CHAR_AMP) begin
                        t = cleared(t);
                        store_byte(side, 8'd0, w.data);
                        t.open  = 1'b1;
                        t.count = 8'd1;
                        t.kind  = (w.data == uafr_pkg::CHAR_DOLLAR) ?
                                  uafr_pkg::KIND_DOLLAR : uafr_pkg::KIND_COMMAND;
                    end
                end else if (!t.done) begin
                    if (t.count >= t.max_len) begin
                        t = cleared(t);
                        r.dropped = 1'b1;
                    end else begin
                        store_byte(side, t.count, w.data);
                        if (t.count == 8'd1)
                            t.length = w.data;
                        t.count = t.count + 8'd1;
                        if ({1'b0, t.count} == {1'b0, t.length} + 9'd2)
                            t.done = 1'b1;
                    end
                end
            end
            uafr_pkg::OP_READ: begin
                r.entry = frame_mem[side][w.index];
            end
            uafr_pkg::OP_RELEASE: begin
                if (t.done)
                    t = cleared(t);
            end
            default: begin
            end
        endcase
        if (t.done)
            r.status = uafr_pkg::ST_COMPLETE;
        else if (t.cr)
            r.status = uafr_pkg::ST_CR_SEEN;
        else if (t.open)
            r.status = uafr_pkg::ST_RECEIVE;
        else
            r.status = uafr_pkg::ST_IDLE;
        r.kind   = t.kind;
        r.count  = t.count;
        r.length = t.length;
        trk[side] = t;
        return r;
    endfunction

    function automatic string report_text(input t_frame_report r);
        return $sformatf("status %0d kind %0d count %0d length %0d byte %0d dropped %0d",
                         r.status, r.kind, r.count, r.length, r.entry, r.dropped);
    endfunction

    function automatic void note_error(input string what, input t_frame_report exp_r,
                                       input t_frame_report got_r);
        report_errors++;
        if (report_errors <= 10)
            $display("%0t ns %s: expected %s, got %s", $time, what,
                     report_text(exp_r), report_text(got_r));
    endfunction

    // Sender side: a word stays offered until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!in_flight) begin
            if (rx_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {rx_words[0].index, rx_words[0].data};
                s_axis_tuser  <= rx_words[0].op;
                in_flight = 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side, with an optional long hold counted here.
    always @(negedge i_clk) begin
        if (hold_start != 0) begin
            hold_left  = hold_start;
            hold_start = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_report got;
        t_frame_report want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                frame_reports.push_back(receive_word(CHK, rx_words.pop_front()));
                in_flight = 1'b0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[1:0], m_axis_tuser, m_axis_tdata[9:2],
                       m_axis_tdata[17:10], m_axis_tdata[25:18], m_axis_tdata[26]};
                if (frame_reports.size() == 0) begin
                    note_error("word with nothing expected", '0, got);
                end else begin
                    want = frame_reports.pop_front();
                    if (got != want)
                        note_error("mismatch", want, got);
                end
            end
        end
    end

    task automatic drain();
        while (rx_words.size() != 0 || frame_reports.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == uafr_pkg::REG_FRAME_MODE) begin
            trk[GEN].mode = value[0];
            trk[GEN] = cleared(trk[GEN]);
            want = 32'(value[0]);
        end else begin
            trk[GEN].max_len = value[7:0];
            want = 32'(value[7:0]);
        end
        trk[CHK] = trk[GEN];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata != want) begin
            report_errors++;
            if (report_errors <= 10)
                $display("%0t ns register %0d read back %0h, expected %0h",
                         $time, idx, prdata, want);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic put(input uafr_pkg::t_op op, input logic [7:0] data,
                       input logic [7:0] index);
        t_rx_word w;
        w.op    = op;
        w.data  = data;
        w.index = index;
        void'(receive_word(GEN, w));
        rx_words.push_back(w);
        words_made++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        put(uafr_pkg::OP_BYTE, b, 8'($urandom_range(255)));
    endtask

    task automatic put_read();
        logic [7:0] idx;
        int         k;
        idx = 8'($urandom_range(255));
        for (k = 0; k < 256 && !mem_written[GEN][idx]; k++)
            idx = idx + 8'd1;
        if (mem_written[GEN][idx])
            put(uafr_pkg::OP_READ, 8'($urandom_range(255)), idx);
        else
            put(uafr_pkg::OP_NONE, 8'($urandom_range(255)), idx);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == uafr_pkg::CHAR_CR || b == uafr_pkg::CHAR_LF)
            b = 8'h7e;
        return b;
    endfunction

    // term: 0 ends with CR LF, 1 with CR and a stray byte, 2 not at all.
    task automatic send_line(input int n, input int term, input bit clean);
        int i;
        for (i = 0; i < n; i++) begin
            if (clean || $urandom_range(99) < 95)
                put_byte(plain_byte());
            else
                put_byte(8'($urandom_range(255)));
        end
        if (term < 2)
            put_byte(uafr_pkg::CHAR_CR);
        if (term == 0)
            put_byte(uafr_pkg::CHAR_LF);
        else if (term == 1)
            put_byte(plain_byte());
    endtask

    task automatic random_line();
        int r;
        int n;
        int term;
        r = $urandom_range(99);
        n = (r < 80) ? $urandom_range(12) : (r < 95) ? $urandom_range(60, 13)
                                                     : $urandom_range(260, 61);
        r = $urandom_range(99);
        term = (r < 80) ? 0 : (r < 90) ? 1 : 2;
        send_line(n, term, 1'b0);
        if ($urandom_range(99) < 80)
            put(uafr_pkg::OP_RELEASE, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic random_frame();
        int         r;
        int         n;
        int         i;
        logic [7:0] len;
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range(255)));
        put_byte(($urandom_range(1) != 0) ? uafr_pkg::CHAR_DOLLAR : uafr_pkg::CHAR_AMP);
        r = $urandom_range(99);
        len = (r < 75) ? 8'($urandom_range(12)) : (r < 95) ? 8'($urandom_range(60, 13))
                                                           : 8'($urandom_range(255, 61));
        put_byte(len);
        n = int'(len);
        if ($urandom_range(99) < 10)
            n = $urandom_range(len);
        for (i = 0; i < n; i++)
            put_byte(8'($urandom_range(255)));
        if ($urandom_range(99) < 80)
            put(uafr_pkg::OP_RELEASE, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop;
        int          r;
        stop = words_made + count;
        while (words_made < stop) begin
            r = $urandom_range(99);
            if (r < 70) begin
                if (trk[GEN].mode == uafr_pkg::MODE_LINE)
                    random_line();
                else
                    random_frame();
            end else if (r < 85) begin
                repeat ($urandom_range(3, 1)) put_read();
            end else if (r < 92) begin
                put(uafr_pkg::OP_RELEASE, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (r < 96) begin
                put(uafr_pkg::OP_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else begin
                put_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        trk[GEN] = '0;
        trk[GEN].mode = uafr_pkg::FRAME_MODE_RESET;
        trk[GEN].max_len = uafr_pkg::MAX_LENGTH_RESET;
        trk[CHK] = trk[GEN];
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Length frames at reset settings: hunting, a short frame, a zero length frame.
        put_byte(8'h00);
        put_byte(8'hff);
        put(uafr_pkg::OP_RELEASE, 8'h00, 8'h00);
        put(uafr_pkg::OP_NONE, 8'hff, 8'hff);
        put_byte(uafr_pkg::CHAR_DOLLAR);
        put_byte(8'd2);
        put_byte(8'hff);
        put_byte(8'h00);
        put_byte(8'h41);
        put(uafr_pkg::OP_READ, 8'h00, 8'd0);
        put(uafr_pkg::OP_READ, 8'hff, 8'd3);
        put(uafr_pkg::OP_RELEASE, 8'hff, 8'h00);
        put_byte(uafr_pkg::CHAR_AMP);
        put_byte(8'd0);
        put(uafr_pkg::OP_RELEASE, 8'h00, 8'hff);
        drain();

        // Lines at max_length 3: completion, an overrun that drops the line, a CR without LF.
        reg_write(uafr_pkg::REG_FRAME_MODE, 32'(uafr_pkg::MODE_LINE));
        reg_write(uafr_pkg::REG_MAX_LENGTH, 32'd3);
        put_byte(8'h61);
        put_byte(8'h62);
        put_byte(uafr_pkg::CHAR_CR);
        put_byte(uafr_pkg::CHAR_LF);
        put(uafr_pkg::OP_RELEASE, 8'h00, 8'h00);
        put_byte(8'h63);
        put_byte(8'h64);
        put_byte(8'h65);
        put_byte(uafr_pkg::CHAR_CR);
        put_byte(8'h78);
        drain();

        // Overrun of a length frame.
        reg_write(uafr_pkg::REG_FRAME_MODE, 32'(uafr_pkg::MODE_LENGTH));
        put_byte(uafr_pkg::CHAR_AMP);
        put_byte(8'd5);
        put_byte(8'h55);
        put_byte(8'haa);
        drain();

        reg_write(uafr_pkg::REG_MAX_LENGTH, 32'd255);
        run_random(120);
        drain();

        // A line that fills every buffer position.
        reg_write(uafr_pkg::REG_FRAME_MODE, 32'(uafr_pkg::MODE_LINE));
        idle_pct = 47;
        send_line(254, 0, 1'b1);
        put_read();
        put(uafr_pkg::OP_READ, 8'h00, 8'd255);
        put(uafr_pkg::OP_RELEASE, 8'h00, 8'h00);
        run_random(90);
        drain();

        reg_write(uafr_pkg::REG_MAX_LENGTH, 32'($urandom_range(20, 3)));
        idle_pct = 0;
        stall_pct = 47;
        run_random(120);
        drain();

        reg_write(uafr_pkg::REG_FRAME_MODE, 32'(uafr_pkg::MODE_LENGTH));
        reg_write(uafr_pkg::REG_MAX_LENGTH, 32'd3);
        idle_pct = 18;
        stall_pct = 18;
        run_random(90);
        drain();

        reg_write(uafr_pkg::REG_MAX_LENGTH, 32'($urandom_range(200, 20)));
        idle_pct = 0;
        stall_pct = 0;
        run_random(100);
        hold_start = 60;
        drain();

        reg_write(uafr_pkg::REG_FRAME_MODE, 32'(uafr_pkg::MODE_LINE));
        reg_write(uafr_pkg::REG_MAX_LENGTH, 32'(uafr_pkg::MAX_LENGTH_RESET));
        idle_pct = 18;
        stall_pct = 18;
        run_random(90);
        drain();

        if (report_errors == 0 && frame_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/uafr_pkg.sv
sv/uart_frame_receiver.sv
sv/uafr_checker.sv
tb/sv/tb_uart_frame_receiver.sv
